/* rtl/assert_macros.svh */
// assertion helpers, included by open_address_hash_set.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/oahs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package oahs_pkg;

   // width of the table size register and of slot positions
   localparam int CFG_W = 5;

   // slot status codes
   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_TOMB  = 2'd2;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_HASH  = 4'b0100,
      S_PROBE = 4'b1000
   } state_type;

endpackage

`default_nettype wire

/* rtl/open_address_hash_set.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake          word
// request   start / busy       req_cmd, req_key
// response  rsp_strobe         rsp_ok
// csr       csr_we             csr_wdata (table size)
//
// a request is taken when start is high and busy low; busy drops in the cycle
// the response strobe is high, so the next word can be taken at its end
// the home slot is worked out one sum bit at a time, then the slots are visited
// one at a time through the status/key memory read port
// an unknown command answers on the cycle after it is taken
// after reset the status memory is swept slot by slot with busy high
// the response strobe lasts one cycle and cannot be held off
`include "assert_macros.svh"

module open_address_hash_set
   import oahs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BYTES   = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [63:0]       req_key,
   output logic                   rsp_strobe,
   output logic                   rsp_ok,
   input  wire logic              csr_we,
   input  wire logic [CFG_W-1:0]  csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KW = 8 * KEY_BYTES;
   localparam int SW = $clog2(255 * KEY_BYTES + 1);
   localparam int BW = (SW > 1) ? $clog2(SW) : 1;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  tsize_ff, tsize_in;
   logic [CFG_W-1:0]  m_ff, m_in, m_cur;
   logic [1:0]        cmd_ff, cmd_in;
   logic [KW-1:0]     key_ff, key_in, key_norm;
   logic [SW-1:0]     sum_ff, sum_in, key_sum;
   logic [BW-1:0]     bit_ff, bit_in;
   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [CFG_W-1:0]  pos_ff, pos_in;
   logic [CFG_W-1:0]  home_ff, home_in;
   logic [CFG_W-1:0]  step_ff, step_in;
   logic [CFG_W-1:0]  j_ff, j_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_ok_ff, rsp_ok_in;

   // slot memories
   logic [1:0]        st_mem [TABLE_DEPTH];
   logic [KW-1:0]     key_mem [TABLE_DEPTH];
   logic [1:0]        rd_st_ff;
   logic [KW-1:0]     rd_key_ff;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              st_we, key_we;
   logic [1:0]        st_wdata;

   logic              accept;
   logic [CFG_W:0]    rem_try;
   logic [CFG_W:0]    pos_sum, pos_red;
   logic [CFG_W:0]    step_sum, step_red1, step_red2;
   logic [CFG_W:0]    j_next;
   logic [CFG_W-1:0]  pos_nx;
   logic              st_full, st_empty, key_hit;
   logic              last_visit, hit, hit_ok;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // effective table size
   always_comb begin
      if (tsize_ff == '0) begin
         m_cur = CFG_W'(1);
      end else if (32'(tsize_ff) > TABLE_DEPTH) begin
         m_cur = CFG_W'(TABLE_DEPTH);
      end else begin
         m_cur = tsize_ff;
      end
   end

   // key normalization and byte sum
   always_comb begin
      logic       alive;
      logic [7:0] kbyte;
      alive    = 1'b1;
      key_norm = '0;
      key_sum  = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         kbyte = req_key[8*b +: 8];
         alive = alive && (kbyte != 8'd0);
         if (alive) begin
            key_norm[8*b +: 8] = kbyte;
            key_sum = key_sum + SW'(kbyte);
         end
      end
   end

   // one remainder bit per hash cycle
   assign rem_try = {rem_ff, sum_ff[bit_ff]};

   // probe decision on the word read back
   assign st_full  = (rd_st_ff == ST_FULL);
   assign st_empty = (rd_st_ff == ST_EMPTY);
   assign key_hit  = (rd_key_ff == key_ff);

   assign pos_sum = {1'b0, pos_ff} + {1'b0, step_ff};
   assign pos_red = (pos_sum >= {1'b0, m_ff}) ? pos_sum - {1'b0, m_ff} : pos_sum;
   assign pos_nx  = pos_red[CFG_W-1:0];

   assign step_sum  = {1'b0, step_ff} + (CFG_W+1)'(2);
   assign step_red1 = (step_sum >= {1'b0, m_ff}) ? step_sum - {1'b0, m_ff} : step_sum;
   assign step_red2 = (step_red1 >= {1'b0, m_ff}) ? step_red1 - {1'b0, m_ff} : step_red1;

   assign j_next     = {1'b0, j_ff} + (CFG_W+1)'(1);
   assign last_visit = (j_next == {1'b0, m_ff}) || (pos_nx == home_ff);

   always_comb begin
      if (cmd_ff == CMD_INSERT) begin
         hit    = !st_full || key_hit;
         hit_ok = 1'b1;
      end else begin
         hit    = st_empty || (st_full && key_hit);
         hit_ok = st_full && key_hit;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tsize_in      = tsize_ff;
      m_in          = m_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      sum_in        = sum_ff;
      bit_in        = bit_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      home_in       = home_ff;
      step_in       = step_ff;
      j_in          = j_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_ok_in     = rsp_ok_ff;
      st_we         = 1'b0;
      key_we        = 1'b0;
      st_wdata      = ST_EMPTY;
      wr_addr       = AW'(pos_ff);

      if (csr_we) begin
         tsize_in = csr_wdata;
      end

      case (state_ff)
         S_CLEAR: begin
            st_we   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_INSERT || req_cmd == CMD_FIND ||
                   req_cmd == CMD_DELETE) begin
                  state_in = S_HASH;
                  cmd_in   = req_cmd;
                  key_in   = key_norm;
                  sum_in   = key_sum;
                  m_in     = m_cur;
                  bit_in   = BW'(SW - 1);
                  rem_in   = '0;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b0;
               end
            end
         end
         S_HASH: begin
            rem_in = (rem_try >= {1'b0, m_ff}) ? CFG_W'(rem_try - {1'b0, m_ff})
                                               : CFG_W'(rem_try);
            bit_in = bit_ff - BW'(1);
            if (bit_ff == '0) begin
               state_in = S_PROBE;
               pos_in   = rem_in;
               home_in  = rem_in;
               step_in  = (m_ff == CFG_W'(1)) ? '0 : CFG_W'(1);
               j_in     = '0;
            end
         end
         S_PROBE: begin
            if (hit || last_visit) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_ok_in     = hit ? hit_ok : (cmd_ff == CMD_INSERT);
               if (cmd_ff == CMD_INSERT && !st_full) begin
                  st_we    = 1'b1;
                  key_we   = 1'b1;
                  st_wdata = ST_FULL;
               end else if (cmd_ff == CMD_DELETE && st_full && key_hit) begin
                  st_we    = 1'b1;
                  st_wdata = ST_TOMB;
               end
            end else begin
               pos_in  = pos_nx;
               step_in = step_red2[CFG_W-1:0];
               j_in    = j_next[CFG_W-1:0];
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // the read follows the next probe position
   assign rd_addr = AW'(pos_in);

   // memory ports
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[wr_addr] <= st_wdata;
      end
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      rd_st_ff  <= st_mem[rd_addr];
      rd_key_ff <= key_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         tsize_ff      <= CFG_W'(5);
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tsize_ff      <= tsize_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      sum_ff    <= sum_in;
      bit_ff    <= bit_in;
      rem_ff    <= rem_in;
      pos_ff    <= pos_in;
      home_ff   <= home_in;
      step_ff   <= step_in;
      j_ff      <= j_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_ok     = rsp_ok_ff;

   // checks
   `ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy, "not busy after reset")
   `ASSERT_CLK(a_valid_cmd_busy, clock, reset, (accept && (req_cmd == CMD_INSERT || req_cmd == CMD_FIND || req_cmd == CMD_DELETE)) |=> busy, "valid command did not start work")
   `ASSERT_CLK(a_probe_bounds, clock, reset,
      (state_ff == S_PROBE) |-> (j_ff < m_ff && pos_ff < m_ff), "probe out of range")
   `ASSERT_CLK(a_rsp_source, clock, reset,
      rsp_strobe |-> ($past(state_ff == S_PROBE) || $past(accept)),
      "response without a word")

endmodule

`default_nettype wire
